FILE: design/open_addressing_hash_table_defines.svh
// Assertion macros for the open-addressing hash table checker.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OAHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oaht assertion failed");

// next-cycle implication, disabled during reset
`define OAHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oaht assertion failed");

`endif

FILE: design/oaht_pkg.sv
// Shared types, constants and helper functions for the hash table.
`default_nettype none
package oaht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 7;
    localparam int KEY_W       = 6;
    localparam int ID_W        = 13;
    localparam int DEPT_W      = 24;
    localparam int NAME_W      = 32;
    localparam int ENTRY_W     = ID_W + DEPT_W + NAME_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(7);
    localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(TABLE_DEPTH);
    localparam logic [SIZE_W-1:0] LIMIT_MIN = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] LIMIT_MAX = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROBE_MODE  = 2'd0,
        CFG_TABLE_SIZE  = 2'd1,
        CFG_PROBE_LIMIT = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_LIMIT     = 3'd4
    } t_status;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req;

    typedef enum logic {
        MODE_DOUBLE = 1'b0,
        MODE_QUAD   = 1'b1
    } t_mode;

    typedef struct packed {
        logic load;
        logic adv;
    } t_probe_ctl;

    // val mod m for val < 32*m, restoring reduction
    function automatic logic [SIZE_W-1:0] mod_reduce(logic [SIZE_W-1:0] val,
                                                     logic [SIZE_W-1:0] m);
        logic [SIZE_W+4:0] rem;
        logic [SIZE_W+4:0] sub;
        rem = {5'd0, val};
        for (int k = 4; k >= 0; k--) begin
            sub = {5'd0, m} << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[SIZE_W-1:0];
    endfunction

    // key mod 7 for a 6-bit key
    function automatic logic [2:0] key_mod7(logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] rem;
        logic [KEY_W-1:0] sub;
        rem = key;
        for (int k = 3; k >= 0; k--) begin
            sub = KEY_W'(7) << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[2:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/oaht_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: design/oaht_probe.sv
// Probe sequence generator: home slot and incremental double/quadratic steps.
`default_nettype none
module oaht_probe (
    input  wire logic                         i_clk,
    input  wire oaht_pkg::t_probe_ctl         i_ctl,
    input  wire logic [oaht_pkg::KEY_W-1:0]   i_key,
    input  wire logic                         i_mode,
    input  wire logic [oaht_pkg::SIZE_W-1:0]  i_size,
    output logic      [oaht_pkg::IDX_W-1:0]   o_idx
);

    logic [oaht_pkg::IDX_W-1:0]  r_idx;
    logic [oaht_pkg::SIZE_W-1:0] r_inc;
    logic [2:0]                  r_step;

    logic [oaht_pkg::SIZE_W-1:0] home;
    logic [oaht_pkg::SIZE_W-1:0] add;
    logic [oaht_pkg::SIZE_W-1:0] sum;
    logic [oaht_pkg::SIZE_W-1:0] n_idx;
    logic [oaht_pkg::SIZE_W-1:0] inc_sum;
    logic [oaht_pkg::SIZE_W-1:0] n_inc;

    always_comb begin
        home    = oaht_pkg::mod_reduce({i_key, 1'b0}, i_size);
        add     = (i_mode == oaht_pkg::MODE_QUAD) ? r_inc
                                                  : {{(oaht_pkg::SIZE_W-3){1'b0}}, r_step};
        sum     = {1'b0, r_idx} + add;
        n_idx   = (sum >= i_size) ? sum - i_size : sum;
        inc_sum = r_inc + oaht_pkg::SIZE_W'(2);
        n_inc   = (inc_sum >= i_size) ? inc_sum - i_size : inc_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_idx  <= home[oaht_pkg::IDX_W-1:0];
            r_inc  <= oaht_pkg::SIZE_W'(1);
            r_step <= 3'd7 - oaht_pkg::key_mod7(i_key);
        end else if (i_ctl.adv) begin
            r_idx <= n_idx[oaht_pkg::IDX_W-1:0];
            r_inc <= n_inc;
        end
    end

    assign o_idx = r_idx;

endmodule
`default_nettype wire

FILE: design/open_addressing_hash_table.sv
// Top level of the open-addressing hash table with a sequential probe engine.
// A request ends at o_done when a free slot is found, on a match, or at the probe limit;
// the number of slots probed lies in 1..limit.
// One request at a time, next start taken in the strobe cycle; the receiver cannot stall.
// A taken slot passes S_PROBE (registered RAM read), then S_CMP (compare); a free slot ends in S_PROBE.
// Reset (synchronous, active low) clears all taken bits at once and loads default config.
`default_nettype none
module open_addressing_hash_table (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_req_type,
    input  wire logic [4:0]                       i_id_letter,
    input  wire logic [3:0]                       i_id_digit_high,
    input  wire logic [3:0]                       i_id_digit_low,
    input  wire logic [oaht_pkg::DEPT_W-1:0]      i_dept_code,
    input  wire logic [oaht_pkg::NAME_W-1:0]      i_name_handle,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [oaht_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [oaht_pkg::SIZE_W-1:0]      i_cfg_data,
    output logic                                  o_done,
    output logic [2:0]                            o_status,
    output logic [5:0]                            o_slot_index,
    output logic [oaht_pkg::DEPT_W-1:0]           o_found_dept,
    output logic [oaht_pkg::NAME_W-1:0]           o_found_name
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CMP
    } t_state;

    t_state r_state;

    logic                         r_mode;
    logic [oaht_pkg::SIZE_W-1:0]  r_size;
    logic [oaht_pkg::SIZE_W-1:0]  r_limit;

    logic                         r_req;
    logic [oaht_pkg::ID_W-1:0]    r_id;
    logic [oaht_pkg::KEY_W-1:0]   r_key;
    logic [oaht_pkg::DEPT_W-1:0]  r_dept;
    logic [oaht_pkg::NAME_W-1:0]  r_name;
    logic [oaht_pkg::SIZE_W-1:0]  r_cnt;

    logic [oaht_pkg::TABLE_DEPTH-1:0] r_taken;

    logic                         r_done;
    logic [2:0]                   r_status;
    logic [oaht_pkg::IDX_W-1:0]   r_slot;
    logic [oaht_pkg::DEPT_W-1:0]  r_fdept;
    logic [oaht_pkg::NAME_W-1:0]  r_fname;

    logic [oaht_pkg::SIZE_W-1:0]  eff_size;
    logic [oaht_pkg::SIZE_W-1:0]  eff_limit;
    logic [oaht_pkg::SIZE_W-1:0]  n_cnt;
    logic [oaht_pkg::KEY_W-1:0]   in_key;
    oaht_pkg::t_probe_ctl         probe_ctl;
    logic [oaht_pkg::IDX_W-1:0]   idx;
    logic                         ram_we;
    logic [oaht_pkg::ENTRY_W-1:0] ram_wdata;
    logic [oaht_pkg::ENTRY_W-1:0] ram_rdata;
    logic [oaht_pkg::ID_W-1:0]    rd_id;
    logic [oaht_pkg::DEPT_W-1:0]  rd_dept;
    logic [oaht_pkg::NAME_W-1:0]  rd_name;
    logic                         accept;

    always_comb begin
        if (r_size < oaht_pkg::SIZE_MIN) begin
            eff_size = oaht_pkg::SIZE_MIN;
        end else if (r_size > oaht_pkg::SIZE_MAX) begin
            eff_size = oaht_pkg::SIZE_MAX;
        end else begin
            eff_size = r_size;
        end
        if (r_limit < oaht_pkg::LIMIT_MIN) begin
            eff_limit = oaht_pkg::LIMIT_MIN;
        end else if (r_limit > oaht_pkg::LIMIT_MAX) begin
            eff_limit = oaht_pkg::LIMIT_MAX;
        end else begin
            eff_limit = r_limit;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign in_key      = {1'b0, i_id_letter} + {2'b0, i_id_digit_high}
                       + {2'b0, i_id_digit_low};
    assign n_cnt       = r_cnt + oaht_pkg::SIZE_W'(1);

    assign probe_ctl.load = (r_state == S_HASH);
    assign probe_ctl.adv  = (r_state == S_CMP) && (rd_id != r_id) && (n_cnt < eff_limit);

    oaht_probe u_probe (
        .i_clk  (i_clk),
        .i_ctl  (probe_ctl),
        .i_key  (r_key),
        .i_mode (r_mode),
        .i_size (eff_size),
        .o_idx  (idx)
    );

    assign ram_we    = (r_state == S_PROBE) && !r_taken[idx] && (r_req == oaht_pkg::REQ_INSERT);
    assign ram_wdata = {r_id, r_dept, r_name};
    assign {rd_id, rd_dept, rd_name} = ram_rdata;

    oaht_ram #(
        .WIDTH (oaht_pkg::ENTRY_W),
        .DEPTH (oaht_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (ram_wdata),
        .i_raddr (idx),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= oaht_pkg::MODE_DOUBLE;
            r_size  <= oaht_pkg::SIZE_RST;
            r_limit <= oaht_pkg::LIMIT_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                oaht_pkg::CFG_PROBE_MODE:  r_mode  <= i_cfg_data[0];
                oaht_pkg::CFG_TABLE_SIZE:  r_size  <= i_cfg_data;
                oaht_pkg::CFG_PROBE_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_id   <= {i_id_letter, i_id_digit_high, i_id_digit_low};
            r_key  <= in_key;
            r_dept <= i_dept_code;
            r_name <= i_name_handle;
        end
    end

    // control state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_taken <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_cnt   <= '0;
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    if (!r_taken[idx]) begin
                        r_done  <= 1'b1;
                        r_slot  <= idx;
                        r_fdept <= '0;
                        r_fname <= '0;
                        r_state <= S_IDLE;
                        if (r_req == oaht_pkg::REQ_SEARCH) begin
                            r_status <= oaht_pkg::ST_NOT_FOUND;
                        end else begin
                            r_status     <= oaht_pkg::ST_INSERTED;
                            r_taken[idx] <= 1'b1;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (rd_id == r_id) begin
                        r_done   <= 1'b1;
                        r_slot   <= idx;
                        r_fdept  <= rd_dept;
                        r_fname  <= rd_name;
                        r_status <= (r_req == oaht_pkg::REQ_SEARCH) ? oaht_pkg::ST_FOUND
                                                                    : oaht_pkg::ST_DUPLICATE;
                        r_state  <= S_IDLE;
                    end else if (n_cnt >= eff_limit) begin
                        r_done   <= 1'b1;
                        r_slot   <= idx;
                        r_fdept  <= '0;
                        r_fname  <= '0;
                        r_status <= oaht_pkg::ST_LIMIT;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt   <= n_cnt;
                        r_state <= S_PROBE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;
    assign o_found_dept = r_fdept;
    assign o_found_name = r_fname;

endmodule
`default_nettype wire

FILE: design/oaht_checker.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
`include "open_addressing_hash_table_defines.svh"
module oaht_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_done,
    input wire logic [2:0]                  o_status,
    input wire logic [oaht_pkg::DEPT_W-1:0] o_found_dept,
    input wire logic [oaht_pkg::NAME_W-1:0] o_found_name
);

    `OAHT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `OAHT_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `OAHT_ASSERT_NOW(a_busy_end_done, $fell(busy) && $past(i_rst_n), o_done)
    `OAHT_ASSERT_NOW(a_status_code, o_done, o_status <= oaht_pkg::ST_LIMIT)
    `OAHT_ASSERT_NOW(a_zero_payload, o_done && (o_status == oaht_pkg::ST_INSERTED || o_status == oaht_pkg::ST_NOT_FOUND || o_status == oaht_pkg::ST_LIMIT), o_found_dept == '0 && o_found_name == '0)

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_found_dept (o_found_dept),
    .o_found_name (o_found_name)
);
`default_nettype wire

FILE: bench/open_addressing_hash_table_tb.sv
// Self-checking bench for the open-addressing hash table: directed table, then random beats.
module open_addressing_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oaht_pkg::*;

    typedef struct packed {
        t_req              req;
        logic [4:0]        letter;
        logic [3:0]        digit_hi;
        logic [3:0]        digit_lo;
        logic [DEPT_W-1:0] dept;
        logic [NAME_W-1:0] name;
    } hash_req_t;

    typedef struct packed {
        t_status           status;
        logic [5:0]        slot;
        logic [DEPT_W-1:0] dept;
        logic [NAME_W-1:0] name;
    } hash_resp_t;

    typedef enum logic {
        ROW_LOOKUP,
        ROW_REGISTER
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        hash_req_t         req;
        t_cfg_idx          reg_idx;
        logic [SIZE_W-1:0] reg_data;
        bit                has_golden;
        hash_resp_t        golden;
    } stim_row_t;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_PRINTS      = 50;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_req_type;
    logic [4:0]        i_id_letter;
    logic [3:0]        i_id_digit_high;
    logic [3:0]        i_id_digit_low;
    logic [DEPT_W-1:0] i_dept_code;
    logic [NAME_W-1:0] i_name_handle;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              o_done;
    logic [2:0]        o_status;
    logic [5:0]        o_slot_index;
    logic [DEPT_W-1:0] o_found_dept;
    logic [NAME_W-1:0] o_found_name;

    open_addressing_hash_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_id_letter     (i_id_letter),
        .i_id_digit_high (i_id_digit_high),
        .i_id_digit_low  (i_id_digit_low),
        .i_dept_code     (i_dept_code),
        .i_name_handle   (i_name_handle),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_found_dept    (o_found_dept),
        .o_found_name    (o_found_name)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow table and registers
    logic              occupied    [TABLE_DEPTH];
    logic [ID_W-1:0]   stored_id   [TABLE_DEPTH];
    logic [DEPT_W-1:0] stored_dept [TABLE_DEPTH];
    logic [NAME_W-1:0] stored_name [TABLE_DEPTH];
    t_mode             cur_mode;
    logic [SIZE_W-1:0] cur_size;
    logic [SIZE_W-1:0] cur_limit;

    hash_resp_t        pending_results [$];
    logic [ID_W-1:0]   known_ids [$];
    stim_row_t         directed_rows [$];
    int                mismatch_count = 0;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    function automatic hash_resp_t predict_lookup(hash_req_t r);
        int              key;
        int              size;
        int              limit;
        int              home;
        int              step;
        int              idx;
        logic [ID_W-1:0] id;
        hash_resp_t      resp;
        id    = {r.letter, r.digit_hi, r.digit_lo};
        key   = int'(r.letter) + int'(r.digit_hi) + int'(r.digit_lo);
        size  = int'(cur_size);
        limit = int'(cur_limit);
        if (size < 7) size = 7;
        if (size > TABLE_DEPTH) size = TABLE_DEPTH;
        if (limit < 1) limit = 1;
        if (limit > 64) limit = 64;
        home        = (2 * key) % size;
        step        = 7 - (key % 7);
        resp.status = ST_LIMIT;
        resp.slot   = 6'(home);
        resp.dept   = '0;
        resp.name   = '0;
        for (int probe = 0; probe < limit; probe++) begin
            idx = (home + ((cur_mode == MODE_QUAD) ? probe * probe : probe * step)) % size;
            resp.slot = 6'(idx);
            if (occupied[idx] && stored_id[idx] == id) begin
                resp.status = (r.req == REQ_SEARCH) ? ST_FOUND : ST_DUPLICATE;
                resp.dept   = stored_dept[idx];
                resp.name   = stored_name[idx];
                break;
            end
            if (!occupied[idx]) begin
                if (r.req == REQ_SEARCH) begin
                    resp.status = ST_NOT_FOUND;
                end else begin
                    occupied[idx]    = 1'b1;
                    stored_id[idx]   = id;
                    stored_dept[idx] = r.dept;
                    stored_name[idx] = r.name;
                    resp.status      = ST_INSERTED;
                end
                break;
            end
        end
        return resp;
    endfunction

    function automatic void add_lookup(t_req rq, int letter, int dig_hi, int dig_lo,
                                       logic [DEPT_W-1:0] dept, logic [NAME_W-1:0] name,
                                       bit has_golden = 1'b0, t_status st = ST_INSERTED,
                                       int slot = 0, logic [DEPT_W-1:0] g_dept = '0,
                                       logic [NAME_W-1:0] g_name = '0);
        stim_row_t row;
        row.kind       = ROW_LOOKUP;
        row.req        = '{rq, 5'(letter), 4'(dig_hi), 4'(dig_lo), dept, name};
        row.reg_idx    = CFG_UNUSED;
        row.reg_data   = '0;
        row.has_golden = has_golden;
        row.golden     = '{st, 6'(slot), g_dept, g_name};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_register(t_cfg_idx idx, logic [SIZE_W-1:0] data);
        stim_row_t row;
        row.kind       = ROW_REGISTER;
        row.req        = '0;
        row.reg_idx    = idx;
        row.reg_data   = data;
        row.has_golden = 1'b0;
        row.golden     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap(bit no_idle);
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly live IDs, so duplicates and hits are common
    function automatic hash_req_t random_request();
        hash_req_t       r;
        int              pick;
        bit              wide;
        logic [ID_W-1:0] id;
        pick = $urandom_range(0, 99);
        wide = ($urandom_range(0, 9) == 0);
        id   = {5'($urandom_range(0, wide ? 31 : 25)), 4'($urandom_range(0, wide ? 15 : 9)),
                4'($urandom_range(0, wide ? 15 : 9))};
        if (pick >= 20 && pick < 75 && known_ids.size() > 0) begin
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        end
        r.req = (pick < 40) ? REQ_INSERT : REQ_SEARCH;
        {r.letter, r.digit_hi, r.digit_lo} = id;
        r.dept = DEPT_W'($urandom);
        r.name = $urandom;
        return r;
    endfunction

    // drop start and cfg valid, drain all results, then idle a while
    task automatic settle_idle(int gap);
        start       <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            CFG_PROBE_MODE:  cur_mode  = t_mode'(data[0]);
            CFG_TABLE_SIZE:  cur_size  = data;
            CFG_PROBE_LIMIT: cur_limit = data;
            default: ;
        endcase
    endtask

    // returns at the edge that takes the beat; start stays high
    task automatic drive_request(hash_req_t r, int gap);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= r.req;
        i_id_letter     <= r.letter;
        i_id_digit_high <= r.digit_hi;
        i_id_digit_low  <= r.digit_lo;
        i_dept_code     <= r.dept;
        i_name_handle   <= r.name;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    function automatic void log_request(hash_req_t r, bit has_golden, hash_resp_t golden);
        hash_resp_t resp;
        resp = predict_lookup(r);
        pending_results.push_back(has_golden ? golden : resp);
        if (r.req == REQ_INSERT) known_ids.push_back({r.letter, r.digit_hi, r.digit_lo});
    endfunction

    always @(negedge i_clk) begin : check_results
        hash_resp_t want;
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_slot_index !== want.slot) report_mismatch("slot", o_slot_index, want.slot);
                if (o_found_dept !== want.dept) report_mismatch("dept", o_found_dept, want.dept);
                if (o_found_name !== want.name) report_mismatch("name", o_found_name, want.name);
            end
        end
    end

    initial begin : stimulus
        stim_row_t         row;
        hash_req_t         req;
        bit                no_idle;
        logic [SIZE_W-1:0] mode_val;
        logic [SIZE_W-1:0] size_val;
        logic [SIZE_W-1:0] limit_val;
        logic [SIZE_W-1:0] size_corner  [4];
        logic [SIZE_W-1:0] limit_corner [4];
        start           <= 1'b0;
        i_req_type      <= 1'b0;
        i_id_letter     <= '0;
        i_id_digit_high <= '0;
        i_id_digit_low  <= '0;
        i_dept_code     <= '0;
        i_name_handle   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) occupied[k] = 1'b0;
        cur_mode  = MODE_DOUBLE;
        cur_size  = SIZE_RST;
        cur_limit = LIMIT_MAX;
        size_corner  = '{7'd0, 7'd7, 7'd64, 7'd127};
        limit_corner = '{7'd0, 7'd1, 7'd64, 7'd127};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: double hashing, 11 slots, 64 probes
        add_lookup(REQ_INSERT, 0, 0, 0, '1, '1, 1, ST_INSERTED, 0);
        add_lookup(REQ_SEARCH, 0, 0, 0, '0, '0, 1, ST_FOUND, 0, '1, '1);
        add_lookup(REQ_INSERT, 0, 0, 0, '0, '0, 1, ST_DUPLICATE, 0, '1, '1);
        add_lookup(REQ_SEARCH, 31, 15, 15, '1, '1, 1, ST_NOT_FOUND, 1);
        add_lookup(REQ_INSERT, 31, 15, 15, '0, '0, 1, ST_INSERTED, 1);
        add_lookup(REQ_SEARCH, 31, 15, 15, '1, '1, 1, ST_FOUND, 1);
        add_lookup(REQ_INSERT, 11, 0, 0, 24'h5A5A5A, 32'hA5A5A5A5);
        add_lookup(REQ_SEARCH, 0, 11, 0, '0, '0);
        add_lookup(REQ_SEARCH, 11, 0, 0, '0, '0);
        add_lookup(REQ_INSERT, 0, 0, 11, 24'h0F0F0F, 32'h12345678);
        add_lookup(REQ_INSERT, 25, 9, 9, 24'h800001, 32'h80000001);
        add_lookup(REQ_SEARCH, 1, 2, 3, '0, '0);
        // size and limit below range: clamped to 7 slots and one probe
        add_register(CFG_PROBE_MODE, 7'h7F);
        add_register(CFG_TABLE_SIZE, 7'd0);
        add_register(CFG_PROBE_LIMIT, 7'd0);
        add_register(CFG_UNUSED, 7'h55);
        add_lookup(REQ_INSERT, 0, 0, 7, 24'h111111, 32'h22222222, 1, ST_LIMIT, 0);
        add_lookup(REQ_SEARCH, 0, 0, 7, '0, '0, 1, ST_LIMIT, 0);
        add_lookup(REQ_SEARCH, 0, 0, 0, '0, '0, 1, ST_FOUND, 0, '1, '1);
        add_lookup(REQ_INSERT, 1, 2, 3, 24'hABCDEF, 32'hFEDCBA98);
        // above range: clamped to the full depth
        add_register(CFG_PROBE_MODE, 7'h00);
        add_register(CFG_TABLE_SIZE, 7'd127);
        add_register(CFG_PROBE_LIMIT, 7'd127);
        add_lookup(REQ_INSERT, 31, 15, 15, 24'h333333, 32'h44444444);
        add_lookup(REQ_SEARCH, 31, 15, 15, '0, '0);
        add_lookup(REQ_INSERT, 0, 0, 0, '0, '0);
        add_register(CFG_PROBE_MODE, 7'd1);
        add_register(CFG_TABLE_SIZE, 7'd64);
        add_register(CFG_PROBE_LIMIT, 7'd64);
        add_lookup(REQ_INSERT, 5, 5, 5, 24'h555555, 32'h66666666);
        add_lookup(REQ_SEARCH, 5, 5, 5, '0, '0);
        add_lookup(REQ_SEARCH, 0, 0, 7, '0, '0);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REGISTER) begin
                settle_idle(pick_gap(1'b0));
                write_register(row.reg_idx, row.reg_data);
            end else begin
                drive_request(row.req, pick_gap(1'b0));
                log_request(row.req, row.has_golden, row.golden);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 4) begin
                mode_val  = SIZE_W'(p % 2);
                size_val  = size_corner[p];
                limit_val = limit_corner[3 - p];
            end else begin
                mode_val  = SIZE_W'($urandom_range(0, 127));
                size_val  = SIZE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(7, 64));
                limit_val = SIZE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(1, 64));
            end
            settle_idle(pick_gap(1'b0));
            write_register(CFG_PROBE_MODE, mode_val);
            settle_idle(pick_gap(1'b0));
            write_register(CFG_TABLE_SIZE, size_val);
            settle_idle(pick_gap(1'b0));
            write_register(CFG_PROBE_LIMIT, limit_val);
            if ($urandom_range(0, 2) == 0) begin
                settle_idle(pick_gap(1'b0));
                write_register(CFG_UNUSED, SIZE_W'($urandom_range(0, 127)));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) begin
                req = random_request();
                drive_request(req, pick_gap(no_idle));
                log_request(req, 1'b0, '0);
            end
        end

        start       <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
